// ===== src/multi_source_path_min_select_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MULTI_SOURCE_PATH_MIN_SELECT_CORE_MACROS_SVH
`define MULTI_SOURCE_PATH_MIN_SELECT_CORE_MACROS_SVH

// Generic clocked assertion with asynchronous reset disable.
`define MSPS_ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define MSPS_ASSERT(lbl, prop, msg) \
	`MSPS_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ===== src/msps_pkg.sv =====
// ----------------------------------------------------------------------------
// msps_pkg
// Types, codes and constants of the shortest-path city selector.
// ----------------------------------------------------------------------------
package msps_pkg;

	localparam int ID_W    = 13;
	localparam int DIST_W  = 16;
	localparam int LIMIT_W = 26;
	localparam int HD_W    = 25;
	localparam int SUM_W   = 27;
	localparam int USE_W   = 32;

	localparam logic [HD_W-1:0] UNREACH = 25'd20000000;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_RECOMP = 2'd1;
	localparam logic [1:0] ACT_FIND   = 2'd2;

	localparam logic [1:0] REG_CITY_COUNT = 2'd0;
	localparam logic [1:0] REG_HUB_FIRST  = 2'd1;
	localparam logic [1:0] REG_HUB_SECOND = 2'd2;
	localparam logic [1:0] REG_HUB_THIRD  = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [ID_W-1:0]    city_a;
		logic [ID_W-1:0]    city_b;
		logic [DIST_W-1:0]  distance;
		logic [LIMIT_W-1:0] limit;
		logic [1:0]         dest_count;
		logic [ID_W-1:0]    dest_first;
		logic [ID_W-1:0]    dest_second;
		logic [ID_W-1:0]    dest_third;
	} in_item_t;

	typedef struct packed {
		logic            found;
		logic [ID_W-1:0] city_id;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_INIT, ST_EDGE_RD, ST_DA, ST_DB,
		ST_RB, ST_RA, ST_ROUND, ST_SCAN, ST_DRAIN, ST_BUMP, ST_EMIT
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic clr_wr;
		logic idx_clr;
		logic idx_inc;
		logic add_edge;
		logic set_limit;
		logic init_wr;
		logic e_clr;
		logic e_inc;
		logic cap_edge;
		logic cap_da;
		logic relax_b;
		logic relax_a;
		logic chg_clr;
		logic scan_rd;
		logic bump;
		logic ld_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       idx_last;
		logic       e_last;
		logic       edge_none;
		logic       n_zero;
		logic       computed;
		logic       chg;
		logic       scan_busy;
		logic       have;
		logic [1:0] action;
	} dp_stat_t;

	// Add an edge weight to a distance, saturating at the unreachable mark.
	function automatic logic [HD_W-1:0] sat_add(input logic [HD_W-1:0] d,
		input logic [DIST_W-1:0] w);
		logic [HD_W:0] s;
		s = {1'b0, d} + {{(HD_W+1-DIST_W){1'b0}}, w};
		return (s > {1'b0, UNREACH}) ? UNREACH : s[HD_W-1:0];
	endfunction

endpackage

// ===== src/msps_ram.sv =====
// ----------------------------------------------------------------------------
// msps_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/msps_ctrl.sv =====
// ----------------------------------------------------------------------------
// msps_ctrl
// Sequencer: clearing pass, edge insert, relaxation rounds, scan, result.
// ----------------------------------------------------------------------------
module msps_ctrl import msps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	// state and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_done) begin
					cmd.idx_clr = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.idx_clr = 1'b1;
				case (stat.action)
					ACT_ADD: begin
						cmd.add_edge = 1'b1;
						state_d      = ST_EMIT;
					end
					ACT_RECOMP: begin
						cmd.set_limit = 1'b1;
						state_d       = stat.n_zero ? ST_EMIT : ST_INIT;
					end
					ACT_FIND: begin
						state_d = (stat.computed && !stat.n_zero) ? ST_SCAN : ST_EMIT;
					end
					default: begin
						state_d = ST_EMIT;
					end
				endcase
			end
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (stat.idx_last) begin
					cmd.idx_clr = 1'b1;
					cmd.e_clr   = 1'b1;
					cmd.chg_clr = 1'b1;
					state_d     = stat.edge_none ? ST_EMIT : ST_EDGE_RD;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_EDGE_RD: begin
				state_d = ST_DA;
			end
			ST_DA: begin
				cmd.cap_edge = 1'b1;
				state_d      = ST_DB;
			end
			ST_DB: begin
				cmd.cap_da = 1'b1;
				state_d    = ST_RB;
			end
			ST_RB: begin
				cmd.relax_b = 1'b1;
				state_d     = ST_RA;
			end
			ST_RA: begin
				cmd.relax_a = 1'b1;
				if (stat.e_last) begin
					state_d = ST_ROUND;
				end else begin
					cmd.e_inc = 1'b1;
					state_d   = ST_EDGE_RD;
				end
			end
			ST_ROUND: begin
				if (stat.chg) begin
					cmd.chg_clr = 1'b1;
					cmd.e_clr   = 1'b1;
					state_d     = ST_EDGE_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.idx_last) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (!stat.scan_busy) begin
					state_d = stat.have ? ST_BUMP : ST_EMIT;
				end
			end
			ST_BUMP: begin
				cmd.bump = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/msps_datapath.sv =====
// ----------------------------------------------------------------------------
// msps_datapath
// Registers, counters, edge/distance/use-count memories and compare logic.
// ----------------------------------------------------------------------------
module msps_datapath import msps_pkg::*; #(
	parameter int MAX_CITIES = 4096,
	parameter int MAX_EDGES  = 16384
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [ID_W-1:0] cfg_data,
	input  in_item_t        in_item,
	input  ctl_cmd_t        cmd,
	output dp_stat_t        stat,
	output out_item_t       out_item
);

	localparam int CW  = $clog2(MAX_CITIES);
	localparam int NW  = $clog2(MAX_CITIES + 1);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int EDW = 2 * CW + DIST_W;

	// configuration
	logic [ID_W-1:0]      city_count_q;
	logic [2:0][ID_W-1:0] hub_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= 13'd4096;
			hub_q[0]     <= 13'd1;
			hub_q[1]     <= 13'd2;
			hub_q[2]     <= 13'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CITY_COUNT: city_count_q <= cfg_data;
				REG_HUB_FIRST:  hub_q[0]     <= cfg_data;
				REG_HUB_SECOND: hub_q[1]     <= cfg_data;
				REG_HUB_THIRD:  hub_q[2]     <= cfg_data;
				default:        city_count_q <= city_count_q;
			endcase
		end
	end

	logic [NW-1:0] n_act;
	assign n_act = (32'(city_count_q) > MAX_CITIES) ? NW'(MAX_CITIES) : NW'(city_count_q);

	// hub positions
	logic [2:0]         hub_ok;
	logic [2:0][CW-1:0] hub_idx;
	always_comb begin
		for (int h = 0; h < 3; h++) begin
			hub_ok[h]  = (hub_q[h] != '0) && (32'(hub_q[h]) <= 32'(n_act));
			hub_idx[h] = CW'(32'(hub_q[h]) - 32'd1);
		end
	end

	// item, counters and flags
	in_item_t            item_q;
	logic [CW-1:0]       idx_q;
	logic [EW-1:0]       e_q;
	logic [ECW-1:0]      ecount_q;
	logic                chg_q;
	logic                computed_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic                have_q;
	logic [CW-1:0]       best_q;
	logic [USE_W-1:0]    best_use_q;
	logic [SUM_W-1:0]    best_sum_q;
	logic                v1_q, v2_q;
	logic                add_ok;
	logic                chg_set;

	assign add_ok = (item_q.city_a != '0) && (32'(item_q.city_a) <= 32'(n_act)) &&
		(item_q.city_b != '0) && (32'(item_q.city_b) <= 32'(n_act)) &&
		(32'(ecount_q) < MAX_EDGES);

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			item_q <= in_item;
		end
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			e_q        <= '0;
			ecount_q   <= '0;
			chg_q      <= 1'b0;
			computed_q <= 1'b0;
			limit_q    <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.e_clr) begin
				e_q <= '0;
			end else if (cmd.e_inc) begin
				e_q <= e_q + 1'b1;
			end
			if (cmd.add_edge && add_ok) begin
				ecount_q <= ecount_q + 1'b1;
			end
			if (cmd.chg_clr) begin
				chg_q <= 1'b0;
			end else if (chg_set) begin
				chg_q <= 1'b1;
			end
			if (cmd.set_limit) begin
				limit_q    <= item_q.limit;
				computed_q <= 1'b1;
			end
		end
	end

	// edge store
	logic [EDW-1:0] edge_rd;
	logic [CW-1:0]  er_a, er_b;
	logic [EW-1:0]  edge_waddr;

	assign edge_waddr = ecount_q[EW-1:0];

	msps_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (cmd.add_edge && add_ok),
		.waddr (edge_waddr),
		.wdata ({CW'(32'(item_q.city_a) - 32'd1), CW'(32'(item_q.city_b) - 32'd1),
			item_q.distance}),
		.raddr (e_q),
		.rdata (edge_rd)
	);

	assign er_a = edge_rd[EDW-1 -: CW];
	assign er_b = edge_rd[DIST_W +: CW];

	// current edge
	logic [CW-1:0]          ea_q, eb_q;
	logic [DIST_W-1:0]      ew_q;
	logic                   eskip_q;
	logic [2:0][HD_W-1:0]   da_q, db_q;
	logic [2:0][HD_W-1:0]   drd;

	always_ff @(posedge clk) begin
		if (cmd.cap_edge) begin
			ea_q    <= er_a;
			eb_q    <= er_b;
			ew_q    <= edge_rd[DIST_W-1:0];
			eskip_q <= (NW'(er_a) >= n_act) || (NW'(er_b) >= n_act);
		end
	end

	// distance memory ports
	logic [CW-1:0]        d_raddr, d_waddr;
	logic [2:0]           d_we;
	logic [2:0][HD_W-1:0] d_wdata;
	logic [2:0][HD_W-1:0] relax_t;

	always_comb begin
		d_raddr = idx_q;
		if (cmd.cap_edge) begin
			d_raddr = er_a;
		end else if (cmd.cap_da) begin
			d_raddr = eb_q;
		end
		d_waddr = idx_q;
		d_we    = '0;
		d_wdata = '0;
		relax_t = '0;
		chg_set = 1'b0;
		if (cmd.relax_b) begin
			d_waddr = eb_q;
		end else if (cmd.relax_a) begin
			d_waddr = ea_q;
		end
		for (int h = 0; h < 3; h++) begin
			if (cmd.init_wr) begin
				d_we[h]    = 1'b1;
				d_wdata[h] = (hub_ok[h] && (idx_q == hub_idx[h])) ? '0 : UNREACH;
			end else if (cmd.relax_b) begin
				relax_t[h] = sat_add(da_q[h], ew_q);
				if (!eskip_q && (relax_t[h] < drd[h])) begin
					d_we[h]    = 1'b1;
					d_wdata[h] = relax_t[h];
					chg_set    = 1'b1;
				end
			end else if (cmd.relax_a) begin
				relax_t[h] = sat_add(db_q[h], ew_q);
				if (!eskip_q && (relax_t[h] < da_q[h])) begin
					d_we[h]    = 1'b1;
					d_wdata[h] = relax_t[h];
					chg_set    = 1'b1;
				end
			end
		end
	end

	// hold endpoint distances of the current edge
	always_ff @(posedge clk) begin
		for (int h = 0; h < 3; h++) begin
			if (cmd.cap_da) begin
				da_q[h] <= drd[h];
			end
			if (cmd.relax_b) begin
				db_q[h] <= d_we[h] ? d_wdata[h] : drd[h];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_dist
		msps_ram #(.WIDTH(HD_W), .DEPTH(MAX_CITIES)) u_dist_ram (
			.clk   (clk),
			.we    (d_we[g]),
			.waddr (d_waddr),
			.wdata (d_wdata[g]),
			.raddr (d_raddr),
			.rdata (drd[g])
		);
	end

	// use counts
	logic             u_we;
	logic [CW-1:0]    u_waddr;
	logic [USE_W-1:0] u_wdata, u_rd;

	assign u_we    = cmd.clr_wr || cmd.bump;
	assign u_waddr = cmd.clr_wr ? idx_q : best_q;
	assign u_wdata = cmd.clr_wr ? '0 :
		((best_use_q == '1) ? best_use_q : best_use_q + 1'b1);

	msps_ram #(.WIDTH(USE_W), .DEPTH(MAX_CITIES)) u_use_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.raddr (idx_q),
		.rdata (u_rd)
	);

	// destination hub mask
	function automatic logic [1:0] hub_of(input logic [ID_W-1:0] id,
		input logic [2:0][ID_W-1:0] hubs);
		if (id == hubs[0]) return 2'd0;
		if (id == hubs[1]) return 2'd1;
		if (id == hubs[2]) return 2'd2;
		return 2'd0;
	endfunction

	logic [2:0] mask;
	always_comb begin
		mask = '0;
		if (item_q.dest_count == 2'd0) begin
			mask[0] = 1'b1;
		end
		if (item_q.dest_count >= 2'd1) begin
			mask[hub_of(item_q.dest_first, hub_q)] = 1'b1;
		end
		if (item_q.dest_count >= 2'd2) begin
			mask[hub_of(item_q.dest_second, hub_q)] = 1'b1;
		end
		if (item_q.dest_count == 2'd3) begin
			mask[hub_of(item_q.dest_third, hub_q)] = 1'b1;
		end
	end

	// scan stage one: sum over named hubs, drop hub cities
	logic [CW-1:0]    idx_s1, idx_s2;
	logic [SUM_W-1:0] sum_c, sum_s2;
	logic             hub_hit;
	logic             ok_s2;
	logic [USE_W-1:0] use_s2;
	logic             better;

	always_comb begin
		sum_c = '0;
		for (int h = 0; h < 3; h++) begin
			if (mask[h]) begin
				sum_c = sum_c + SUM_W'(drd[h]);
			end
		end
		hub_hit = (32'(idx_s1) + 32'd1 == 32'(hub_q[0])) ||
			(32'(idx_s1) + 32'd1 == 32'(hub_q[1])) ||
			(32'(idx_s1) + 32'd1 == 32'(hub_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_rd) begin
			idx_s1 <= idx_q;
		end
		if (v1_q) begin
			idx_s2 <= idx_s1;
			sum_s2 <= sum_c;
			ok_s2  <= !hub_hit;
			use_s2 <= u_rd;
		end
	end

	// scan stage two: keep the best candidate
	assign better = ok_s2 && (sum_s2 <= SUM_W'(limit_q)) &&
		(!have_q || (use_s2 < best_use_q) ||
		((use_s2 == best_use_q) && (sum_s2 < best_sum_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			have_q <= 1'b0;
		end else begin
			v1_q <= cmd.scan_rd;
			v2_q <= v1_q;
			if (cmd.latch_in) begin
				have_q <= 1'b0;
			end else if (v2_q && better) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v2_q && better) begin
			best_q     <= idx_s2;
			best_use_q <= use_s2;
			best_sum_q <= sum_s2;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			out_item.found   <= have_q;
			out_item.city_id <= have_q ? ID_W'(32'(best_q) + 32'd1) : '0;
		end
	end

	// status
	assign stat.clr_done  = (32'(idx_q) == MAX_CITIES - 1);
	assign stat.idx_last  = (32'(idx_q) + 32'd1 == 32'(n_act));
	assign stat.e_last    = (32'(e_q) + 32'd1 == 32'(ecount_q));
	assign stat.edge_none = (ecount_q == '0);
	assign stat.n_zero    = (n_act == '0);
	assign stat.computed  = computed_q;
	assign stat.chg       = chg_q;
	assign stat.scan_busy = v1_q || v2_q;
	assign stat.have      = have_q;
	assign stat.action    = item_q.action;

endmodule

// ===== src/multi_source_path_min_select_core.sv =====
// ----------------------------------------------------------------------------
// multi_source_path_min_select_core
// Edge store, three-hub shortest paths and least-used city selection.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_stall, one result item per input item
// leaves on out_valid/out_stall. The user writes registers through cfg_we,
// cfg_index and cfg_data only while the block is idle; it is not enforced.
// One item is worked at a time; a new item is taken once the previous result
// sits in the output register, so that register decouples the two sides.
// States from accepting an item to loading the result, for n active cities:
//   add edge: DISPATCH, then EMIT.
//   find: DISPATCH, SCAN of the n cities, DRAIN, BUMP to write back the
//   use count when a city is found, EMIT; the scan reads the distance and
//   use-count memories one city a cycle.
//   recompute: DISPATCH, INIT of the n cities, relaxation rounds until
//   nothing changes (at most n), EMIT; each edge passes EDGE_RD, DA, DB, RB
//   and RA on the single distance read port; ROUND tests each round for change.
// The next item is taken from the cycle after the result is loaded.
// After reset a clearing pass over every city zeroes the use counts;
// no item is taken meanwhile. Edges and the limit are cleared at once.
// A stalled result holds in the output register; the block then waits with
// the next finished result until the register frees.
// ----------------------------------------------------------------------------
module multi_source_path_min_select_core import msps_pkg::*; #(
	parameter int MAX_CITIES = 4096,
	parameter int MAX_EDGES  = 16384
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  in_item_t        in_item,
	output logic            out_valid,
	input  logic            out_stall,
	output out_item_t       out_item,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [ID_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	msps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	msps_datapath #(.MAX_CITIES(MAX_CITIES), .MAX_EDGES(MAX_EDGES)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item)
	);

endmodule

// ===== src/msps_checker.sv =====
// ----------------------------------------------------------------------------
// msps_checker
// Port-level checks of the city selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_source_path_min_select_core_macros.svh"

module msps_checker import msps_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input in_item_t        in_item,
	input logic            out_valid,
	input logic            out_stall,
	input out_item_t       out_item,
	input logic            cfg_we,
	input logic [1:0]      cfg_index,
	input logic [ID_W-1:0] cfg_data
);

	// a stalled result stays offered
	`MSPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	// an accepted item keeps the input closed in the next cycle
	`MSPS_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "item taken while busy")

	// a result without a city carries ID zero
	`MSPS_ASSERT(a_none_zero, out_valid && !out_item.found |-> out_item.city_id == '0, "stray ID")

endmodule

bind multi_source_path_min_select_core msps_checker u_msps_checker (.*);

// ===== verif/tb_multi_source_path_min_select_core.sv =====
// ----------------------------------------------------------------------------
// tb_multi_source_path_min_select_core
// Self-checking bench for the three-hub shortest-path city selector.
// ----------------------------------------------------------------------------
// A queue of items built by the stimulus process feeds a clocked driver; a
// clocked monitor predicts every accepted item with a behavioural copy of
// the edge store, the hub distances and the use counts, and compares each
// result item field by field. Registers change only while the block is idle,
// and every register setting is followed by a recompute before any find.
// ----------------------------------------------------------------------------
module tb_multi_source_path_min_select_core;
	import msps_pkg::*;

	localparam int          N_MAX     = 4096;
	localparam int          E_MAX     = 16384;
	localparam int unsigned FAR       = 20000000;
	localparam int unsigned LIMIT_TOP = 60000000;
	localparam int          WD_LIMIT  = 800000;

	// action code with no operation behind it
	localparam logic [1:0]  ACT_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;
	logic      cfg_we;
	logic [1:0] cfg_index;
	logic [ID_W-1:0] cfg_data;

	// predictor state
	logic [ID_W-1:0] cur_cities;
	logic [ID_W-1:0] cur_hub [3];
	int unsigned     link_a [$];
	int unsigned     link_b [$];
	int unsigned     link_w [$];
	int unsigned     hub_dist [3][N_MAX];
	int unsigned     city_uses [N_MAX];
	int unsigned     held_limit;
	bit              have_paths;

	in_item_t  pending_q [$];
	out_item_t expected_q [$];
	int        items_queued;
	int        results_seen;
	int        err_count;
	int        finds_hit;
	int        recomputes;
	int        idle_pct;
	int        stall_pct;
	int        gap_left;
	int        stall_left;
	int        quiet_cycles;
	int        planned_links;

	multi_source_path_min_select_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// clock, period 8
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int unsigned live_cities();
		return (cur_cities > N_MAX) ? N_MAX : cur_cities;
	endfunction

	// Bellman-Ford from one hub register, saturating at the far mark
	function automatic void solve_hub(int h, int unsigned n);
		int unsigned hub;
		int unsigned a;
		int unsigned b;
		int unsigned t;
		bit          moved;
		hub = cur_hub[h];
		for (int c = 0; c < n; c++)
			hub_dist[h][c] = FAR;
		if (hub >= 1 && hub <= n)
			hub_dist[h][hub-1] = 0;
		for (int r = 0; r <= n; r++) begin
			moved = 1'b0;
			for (int e = 0; e < link_a.size(); e++) begin
				a = link_a[e];
				b = link_b[e];
				if (a >= n || b >= n)
					continue;
				t = hub_dist[h][a] + link_w[e];
				if (t > FAR) t = FAR;
				if (t < hub_dist[h][b]) begin
					hub_dist[h][b] = t;
					moved = 1'b1;
				end
				t = hub_dist[h][b] + link_w[e];
				if (t > FAR) t = FAR;
				if (t < hub_dist[h][a]) begin
					hub_dist[h][a] = t;
					moved = 1'b1;
				end
			end
			if (!moved)
				break;
		end
	endfunction

	function automatic int hub_slot(logic [ID_W-1:0] id);
		if (id == cur_hub[0]) return 0;
		if (id == cur_hub[1]) return 1;
		if (id == cur_hub[2]) return 2;
		return 0;
	endfunction

	// work out the result of one accepted item and update the state
	function automatic out_item_t select_city(in_item_t it);
		out_item_t   r;
		int unsigned n;
		int unsigned sum;
		int unsigned best;
		int unsigned best_use;
		int unsigned best_sum;
		bit          have;
		logic [2:0]  mask;
		logic [ID_W-1:0] dest [3];
		r = '0;
		n = live_cities();
		if (it.action == ACT_ADD) begin
			if (it.city_a >= 1 && it.city_a <= n && it.city_b >= 1 &&
				it.city_b <= n && link_a.size() < E_MAX) begin
				link_a.insert(link_a.size(), 32'(it.city_a) - 32'd1);
				link_b.insert(link_b.size(), 32'(it.city_b) - 32'd1);
				link_w.insert(link_w.size(), 32'(it.distance));
			end
		end else if (it.action == ACT_RECOMP) begin
			held_limit = it.limit;
			for (int h = 0; h < 3; h++)
				solve_hub(h, n);
			have_paths = 1'b1;
			recomputes++;
		end else if (it.action == ACT_FIND && have_paths) begin
			dest[0] = it.dest_first;
			dest[1] = it.dest_second;
			dest[2] = it.dest_third;
			mask = (it.dest_count == 0) ? 3'b001 : 3'b000;
			for (int i = 0; i < it.dest_count; i++)
				mask[hub_slot(dest[i])] = 1'b1;
			have = 1'b0;
			best = 0;
			best_use = 0;
			best_sum = 0;
			for (int c = 0; c < n; c++) begin
				if (c + 1 == cur_hub[0] || c + 1 == cur_hub[1] || c + 1 == cur_hub[2])
					continue;
				sum = 0;
				for (int h = 0; h < 3; h++)
					if (mask[h])
						sum += hub_dist[h][c];
				if (sum > held_limit)
					continue;
				if (!have || city_uses[c] < best_use ||
					(city_uses[c] == best_use && sum < best_sum)) begin
					have = 1'b1;
					best = c;
					best_use = city_uses[c];
					best_sum = sum;
				end
			end
			if (have) begin
				if (city_uses[best] != 32'hFFFF_FFFF)
					city_uses[best]++;
				r.found = 1'b1;
				r.city_id = ID_W'(best + 1);
				finds_hit++;
			end
		end
		return r;
	endfunction

	// gap length: mostly short, now and then long
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// driver: advance to the next item when the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_q.size() > 0) begin
				in_valid <= 1'b1;
				in_item  <= pending_q.pop_front();
				gap_left <= pick_gap(idle_pct);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= ($urandom_range(0, 99) < stall_pct);
			if (stall_pct > 0 && $urandom_range(0, 199) == 0)
				stall_left <= $urandom_range(10, 40);
		end
	end

	// monitor: predict accepted items, check accepted results
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_q.insert(expected_q.size(), select_city(in_item));
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					$error("result item with nothing expected: found %0d city_id %0d",
						out_item.found, out_item.city_id);
					err_count++;
				end else begin
					want = expected_q.pop_front();
					if (out_item.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, out_item.found);
						err_count++;
					end
					if (out_item.city_id !== want.city_id) begin
						$error("city_id: expected %0d, got %0d", want.city_id,
							out_item.city_id);
						err_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic in_item_t noise_item(logic [1:0] act);
		in_item_t it;
		it.action      = act;
		it.city_a      = ID_W'($urandom);
		it.city_b      = ID_W'($urandom);
		it.distance    = DIST_W'($urandom);
		it.limit       = LIMIT_W'($urandom_range(0, LIMIT_TOP));
		it.dest_count  = 2'($urandom);
		it.dest_first  = ID_W'($urandom);
		it.dest_second = ID_W'($urandom);
		it.dest_third  = ID_W'($urandom);
		return it;
	endfunction

	task automatic queue_item(in_item_t it);
		pending_q.insert(pending_q.size(), it);
		items_queued++;
	endtask

	task automatic queue_link(int a, int b, int w);
		in_item_t it;
		it = noise_item(ACT_ADD);
		it.city_a = ID_W'(a);
		it.city_b = ID_W'(b);
		it.distance = DIST_W'(w);
		queue_item(it);
	endtask

	task automatic queue_recompute(int unsigned lim);
		in_item_t it;
		it = noise_item(ACT_RECOMP);
		it.limit = LIMIT_W'(lim);
		queue_item(it);
	endtask

	task automatic queue_find(int cnt, int d1, int d2, int d3);
		in_item_t it;
		it = noise_item(ACT_FIND);
		it.dest_count = 2'(cnt);
		it.dest_first = ID_W'(d1);
		it.dest_second = ID_W'(d2);
		it.dest_third = ID_W'(d3);
		queue_item(it);
	endtask

	// hold until every item has come back, then let the block settle
	task automatic wait_idle();
		while (results_seen < items_queued)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [ID_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_CITY_COUNT: cur_cities = val;
			REG_HUB_FIRST:  cur_hub[0] = val;
			REG_HUB_SECOND: cur_hub[1] = val;
			default:        cur_hub[2] = val;
		endcase
	endtask

	task automatic set_regs(int n, int h1, int h2, int h3);
		write_reg(REG_CITY_COUNT, ID_W'(n));
		write_reg(REG_HUB_FIRST, ID_W'(h1));
		write_reg(REG_HUB_SECOND, ID_W'(h2));
		write_reg(REG_HUB_THIRD, ID_W'(h3));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_weight();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return 65535;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 100);
		endcase
	endfunction

	function automatic int unsigned pick_limit();
		case ($urandom_range(0, 4))
			0, 1:    return LIMIT_TOP;
			2:       return $urandom_range(0, LIMIT_TOP);
			default: return $urandom_range(0, 300000);
		endcase
	endfunction

	// one random phase: a recompute, then adds, finds, recomputes, unused codes
	task automatic random_phase(int count);
		int n;
		int span;
		int sel;
		n = live_cities();
		span = (n > 12) ? 12 : n;
		queue_recompute(pick_limit());
		for (int i = 1; i < count; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 30 && planned_links < 80) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_link($urandom, $urandom, pick_weight());
				end else begin
					queue_link($urandom_range(1, span), $urandom_range(1, span),
						pick_weight());
					planned_links++;
				end
			end else if (sel < 42) begin
				queue_recompute(pick_limit());
			end else if (sel < 95) begin
				if ($urandom_range(0, 4) == 0)
					queue_find($urandom, $urandom, $urandom, $urandom);
				else
					queue_find($urandom, cur_hub[$urandom_range(0, 2)],
						cur_hub[$urandom_range(0, 2)], cur_hub[$urandom_range(0, 2)]);
			end else begin
				queue_item(noise_item(ACT_UNUSED));
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cur_cities   = ID_W'(4096);
		cur_hub[0]   = ID_W'(1);
		cur_hub[1]   = ID_W'(2);
		cur_hub[2]   = ID_W'(3);
		items_queued = 0;
		planned_links = 0;
		idle_pct     = 30;
		stall_pct    = 25;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default registers, nothing found before the first recompute
		queue_find(1, 1, 1, 1);
		queue_item(noise_item(ACT_UNUSED));
		queue_link(1, 4, 0);
		queue_link(4, 5, 65535);
		queue_link(2, 5, 7);
		queue_link(3, 6, 3);
		queue_link(6, 4, 1);
		queue_link(0, 4, 5);
		queue_link(8191, 2, 5);
		queue_link(4096, 7, 9);
		planned_links = 6;
		queue_recompute(0);
		queue_find(0, 1, 1, 1);
		queue_recompute(LIMIT_TOP);
		queue_find(0, 8191, 0, 0);
		queue_find(3, 1, 2, 3);
		queue_find(3, 2, 2, 2);
		queue_find(2, 3, 99, 0);
		queue_find(1, 4095, 1, 1);
		queue_item(noise_item(ACT_UNUSED));
		wait_idle();

		// smallest city count, then random phases over several settings
		set_regs(4, 1, 2, 3);
		random_phase(14);
		idle_pct = 0;
		stall_pct = 0;
		set_regs(7, 7, 1, 4);
		random_phase(20);
		idle_pct = 40;
		stall_pct = 50;
		set_regs(12, 5, 5, 5);
		random_phase(20);
		idle_pct = 20;
		stall_pct = 10;
		set_regs(9, 2, 9, 13);
		random_phase(20);
		set_regs(4096, 4096, 1, 6);
		random_phase(6);
		set_regs(8191, 0, 3, 8191);
		random_phase(5);
		idle_pct = 60;
		stall_pct = 30;
		set_regs(10, 3, 8, 1);
		random_phase(22);
		set_regs(5, 5, 4, 2);
		random_phase(16);

		wait_idle();
		repeat (50) @(posedge clk);
		$display("Covered %0d items: %0d recomputes, %0d cities selected, %0d edges stored.",
			items_queued, recomputes, finds_hit, link_a.size());
		if (err_count == 0 && expected_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
